// ===== rtl/core/rgbhsl_pkg.sv =====
// types and constants shared by the rgb to hsl converter pipeline
`timescale 1ns / 1ps
`default_nettype none

package rgbhsl_pkg;

    // channel and quotient widths
    localparam int CHAN_W = 8;
    localparam int QUO_W  = 8;

    // hue divider: dividend 255*n with n below 1530, divisor 6*delta
    localparam int HREM_W = 19;
    localparam int HDEN_W = 11;

    // saturation divider: dividend 255*delta, divisor at most 255
    localparam int SREM_W = 16;
    localparam int SDEN_W = 8;

    // full scale of a channel
    localparam logic [CHAN_W:0] FULL_SCALE = 9'd255;

    typedef struct packed {
        logic [HREM_W-1:0] rem;
        logic [HDEN_W-1:0] den;
        logic [QUO_W-1:0]  quo;
    } t_hue_div;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [SDEN_W-1:0] den;
        logic [QUO_W-1:0]  quo;
    } t_sat_div;

    // payload carried down the divider stages
    typedef struct packed {
        t_hue_div          hue;
        t_sat_div          sat;
        logic [CHAN_W-1:0] light;
        logic              gray;
    } t_pipe;

endpackage

`default_nettype wire

// ===== rtl/core/rgbhsl_front.sv =====
// first stage: max/min, lightness, hue numerator and divider set-up
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_front
    import rgbhsl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [CHAN_W-1:0] i_red,
    input  wire logic [CHAN_W-1:0] i_green,
    input  wire logic [CHAN_W-1:0] i_blue,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output t_pipe                  o_data
);

    logic [CHAN_W-1:0] w_max;
    logic [CHAN_W-1:0] w_min;
    logic [CHAN_W:0]   w_sum;
    logic [CHAN_W-1:0] w_delta;
    logic [HDEN_W-1:0] w_six_d;
    logic signed [HDEN_W:0] w_n;
    logic [HDEN_W-1:0] w_n_pos;
    logic [CHAN_W:0]   w_den;
    t_pipe             n_data;
    t_pipe             r_data;
    logic              r_valid;

    // largest and smallest channel
    always_comb begin
        w_max = (i_red > i_green) ? i_red : i_green;
        if (i_blue > w_max) begin
            w_max = i_blue;
        end
        w_min = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_min) begin
            w_min = i_blue;
        end
    end

    assign w_sum   = {1'b0, w_max} + {1'b0, w_min};
    assign w_delta = w_max - w_min;
    assign w_six_d = ({3'b0, w_delta} << 2) + ({3'b0, w_delta} << 1);

    // hue numerator, largest channel tested red first
    always_comb begin
        if (i_red == w_max) begin
            w_n = $signed({4'b0, i_green}) - $signed({4'b0, i_blue});
        end else if (i_green == w_max) begin
            w_n = $signed({3'b0, w_delta, 1'b0}) + $signed({4'b0, i_blue})
                - $signed({4'b0, i_red});
        end else begin
            w_n = $signed({2'b0, w_delta, 2'b0}) + $signed({4'b0, i_red})
                - $signed({4'b0, i_green});
        end
    end

    // wrap a negative numerator into the circle
    always_comb begin
        if (w_n < 0) begin
            w_n_pos = HDEN_W'(w_n + $signed({1'b0, w_six_d}));
        end else begin
            w_n_pos = HDEN_W'(w_n);
        end
    end

    // saturation divisor folds around full scale
    assign w_den = (w_sum < FULL_SCALE) ? w_sum : (9'd510 - w_sum);

    // times 255 as shift and subtract
    always_comb begin
        n_data.hue.rem = ({8'b0, w_n_pos} << 8) - {8'b0, w_n_pos};
        n_data.hue.den = w_six_d;
        n_data.hue.quo = '0;
        n_data.sat.rem = ({8'b0, w_delta} << 8) - {8'b0, w_delta};
        n_data.sat.den = w_den[SDEN_W-1:0];
        n_data.sat.quo = '0;
        n_data.light   = w_sum[CHAN_W:1];
        n_data.gray    = (w_delta == '0);
    end

    // stage register with per-stage flow control
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/rgbhsl_div_stage.sv =====
// one restoring division step for the hue and saturation dividers
`timescale 1ns / 1ps
`default_nettype none

module rgbhsl_div_stage
    import rgbhsl_pkg::*;
#(
    parameter int BIT_IDX = QUO_W - 1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_pipe i_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_pipe      o_data
);

    logic [HREM_W-1:0] w_hue_sub;
    logic [SREM_W-1:0] w_sat_sub;
    t_pipe             n_data;
    t_pipe             r_data;
    logic              r_valid;

    // divisor aligned to this quotient bit
    assign w_hue_sub = {{(HREM_W-HDEN_W){1'b0}}, i_data.hue.den} << BIT_IDX;
    assign w_sat_sub = {{(SREM_W-SDEN_W){1'b0}}, i_data.sat.den} << BIT_IDX;

    // compare and subtract on both lanes
    always_comb begin
        n_data = i_data;
        if (i_data.hue.rem >= w_hue_sub) begin
            n_data.hue.rem          = i_data.hue.rem - w_hue_sub;
            n_data.hue.quo[BIT_IDX] = 1'b1;
        end
        if (i_data.sat.rem >= w_sat_sub) begin
            n_data.sat.rem          = i_data.sat.rem - w_sat_sub;
            n_data.sat.quo[BIT_IDX] = 1'b1;
        end
    end

    // stage register with per-stage flow control
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_to_hsl_pixel_converter_unit.sv =====
// top level of the rgb to hsl pixel converter
//
//  channel  dir  tdata fields (low bit up)                  handshake
//  s        in   red[7:0] green[15:8] blue[23:16]           i_s_tvalid / o_s_tready
//  m        out  hue[7:0] saturation[15:8] lightness[23:16] o_m_tvalid / i_m_tready
//
// one item per cycle sustained while the output is ready; one set-up stage and
// eight restoring division stages, one quotient bit each for hue and saturation
// every stage holds its own valid bit and takes a new item when it is empty
// or its successor moves, so bubbles close up under output stalls
// synchronous active-low reset clears the valid bits only
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_pixel_converter_unit
    import rgbhsl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // red, green, blue
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // hue, saturation, lightness
);

    t_pipe w_data  [0:QUO_W];
    logic  w_valid [0:QUO_W];
    logic  w_ready [0:QUO_W];

    // set-up stage
    rgbhsl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_red   (i_s_tdata[7:0]),
        .i_green (i_s_tdata[15:8]),
        .i_blue  (i_s_tdata[23:16]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_data  (w_data[0])
    );

    // division stages, most significant quotient bit first
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        rgbhsl_div_stage #(
            .BIT_IDX (QUO_W - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    assign w_ready[QUO_W] = i_m_tready;
    assign o_m_tvalid     = w_valid[QUO_W];

    // gray pixels give zero hue and saturation
    assign o_m_tdata[7:0]   = w_data[QUO_W].gray ? '0 : w_data[QUO_W].hue.quo;
    assign o_m_tdata[15:8]  = w_data[QUO_W].gray ? '0 : w_data[QUO_W].sat.quo;
    assign o_m_tdata[23:16] = w_data[QUO_W].light;

`ifndef SYNTHESIS
    // hue never reaches a full circle
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:0] != 8'hFF))
        else $error("hue out of range");

    // zero saturation only for gray, which also has zero hue
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[15:8] == 8'h00)) |-> (o_m_tdata[7:0] == 8'h00))
        else $error("zero saturation with nonzero hue");

    // gray items carry zero hue and saturation
    a_light_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_data[QUO_W].gray) |-> (o_m_tdata[15:0] == 16'h0000))
        else $error("gray item with nonzero hue or saturation");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== dv/rgb_to_hsl_pixel_converter_unit_tb.sv =====
// self-checking stream testbench for the rgb to hsl pixel converter
`timescale 1ns / 1ps

module rgb_to_hsl_pixel_converter_unit_tb;
    import rgbhsl_pkg::CHAN_W;

    // one converted pixel
    typedef struct packed {
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] light;
    } t_hsl;

    // directed row: pixel, and the result where it is known by hand
    typedef struct packed {
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        bit                typed;
        t_hsl              want;
    } t_pixel_case;

    localparam int NUM_CASES   = 22;
    localparam int NUM_RANDOM  = 1530;
    localparam int DRAIN_AT    = 700;   // sender waits for an empty pipe here
    localparam int HOLD_AT     = 400;   // receiver holds off after this many results
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // red, green, blue
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // hue, saturation, lightness

    t_hsl hsl_due[$];
    int   hsl_seen;
    int   mismatches;

    // gray, pure primaries, ties for the largest channel, both saturation branches
    t_pixel_case pixel_cases [NUM_CASES] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{8'd0,   8'd0,   8'd128}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{8'd0,   8'd0,   8'd1}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd127}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{8'd85,  8'd255, 8'd127}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd170, 8'd255, 8'd127}},
        '{8'd255, 8'd0,   8'd1,   1'b1, '{8'd254, 8'd255, 8'd127}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd42,  8'd255, 8'd127}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd127, 8'd255, 8'd127}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd212, 8'd255, 8'd127}},
        '{8'd1,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd255, 8'd0}},
        '{8'd254, 8'd0,   8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd200, 8'd55,  8'd55,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd255, 8'd254, 8'd254, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd254, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd0,   8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd85,  8'd170, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd170, 8'd85,  8'd0,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd100, 8'd100, 8'd99,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd10,  8'd200, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
        '{8'd30,  8'd20,  8'd250, 1'b0, '{8'd0,   8'd0,   8'd0}}
    };

    rgb_to_hsl_pixel_converter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // exact integer hsl of one pixel, red in the low byte
    function automatic t_hsl predict_hsl(input logic [23:0] px);
        int   r, g, b, hi, lo, sum, dlt, den, n;
        t_hsl res;
        r   = int'(px[7:0]);
        g   = int'(px[15:8]);
        b   = int'(px[23:16]);
        hi  = (r > g) ? r : g;
        hi  = (hi > b) ? hi : b;
        lo  = (r < g) ? r : g;
        lo  = (lo < b) ? lo : b;
        sum = hi + lo;
        dlt = hi - lo;
        res.light = CHAN_W'(sum >> 1);
        res.hue   = '0;
        res.sat   = '0;
        if (dlt != 0) begin
            den     = (sum < 255) ? sum : 510 - sum;
            res.sat = CHAN_W'((255 * dlt) / den);
            // first channel in red, green, blue order that equals max picks the sector
            if (r == hi) begin
                n = g - b;
            end else if (g == hi) begin
                n = 2 * dlt + b - r;
            end else begin
                n = 4 * dlt + r - g;
            end
            if (n < 0) begin
                n = n + 6 * dlt;
            end
            res.hue = CHAN_W'((255 * n) / (6 * dlt));
        end
        return res;
    endfunction

    // random pixel, biased toward gray, ties and channel extremes
    function automatic logic [23:0] rand_pixel();
        logic [7:0] c [3];
        logic [7:0] base;
        int         kind, k;
        kind = $urandom_range(0, 9);
        base = 8'($urandom);
        for (k = 0; k < 3; k++) begin
            c[k] = 8'($urandom);
        end
        case (kind)
            5: begin
                c[0] = base;
                c[1] = base;
                c[2] = base;
            end
            6: begin
                k = $urandom_range(0, 2);
                c[k] = base;
                c[(k + 1) % 3] = base;
                if (c[(k + 2) % 3] > base) c[(k + 2) % 3] = base;
            end
            7: begin
                for (k = 0; k < 3; k++) begin
                    case ($urandom_range(0, 3))
                        0: c[k] = 8'd0;
                        1: c[k] = 8'd1;
                        2: c[k] = 8'd254;
                        default: c[k] = 8'd255;
                    endcase
                end
            end
            8: begin
                for (k = 0; k < 3; k++) begin
                    c[k] = base ^ 8'($urandom_range(0, 3));
                end
            end
            9: begin
                k = $urandom_range(0, 2);
                c[k] = 8'd0;
                c[(k + 1) % 3] = 8'd255;
            end
            default: ;
        endcase
        return {c[2], c[1], c[0]};
    endfunction

    // offer one item and hold it until taken, then record what must come out
    task automatic send_pixel(input logic [23:0] px, input t_hsl want);
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= px;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        hsl_due.push_back(want);
    endtask

    // sender gap with junk on the data lines
    task automatic idle_for(input int cycles);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 24'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input t_hsl want, input t_hsl got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: expected h=%0d s=%0d l=%0d, got h=%0d s=%0d l=%0d",
                     $realtime, want.hue, want.sat, want.light, got.hue, got.sat, got.light);
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: stretches of always ready, random stalls and periodic stalls
    initial begin
        int  left, mode, period;
        bit  held;
        i_m_tready = 1'b0;
        held       = 1'b0;
        forever begin
            mode   = $urandom_range(0, 2);
            left   = $urandom_range(5, 60);
            period = $urandom_range(2, 5);
            while (left > 0) begin
                @(negedge i_clk);
                if (!held && hsl_seen >= HOLD_AT) begin
                    // long hold-off so the pipe fills and back-pressures the input
                    held = 1'b1;
                    i_m_tready <= 1'b0;
                    repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                end else begin
                    case (mode)
                        0: i_m_tready <= 1'b1;
                        1: i_m_tready <= 1'($urandom_range(0, 1));
                        default: i_m_tready <= ((left % period) != 0);
                    endcase
                end
                left--;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_hsl got, want;
        if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
            got.hue   = o_m_tdata[7:0];
            got.sat   = o_m_tdata[15:8];
            got.light = o_m_tdata[23:16];
            hsl_seen++;
            if (hsl_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item at %0t: h=%0d s=%0d l=%0d",
                             $realtime, got.hue, got.sat, got.light);
                end
            end else begin
                want = hsl_due.pop_front();
                if (got.hue !== want.hue || got.sat !== want.sat ||
                    got.light !== want.light) begin
                    report_mismatch(want, got);
                end
            end
        end
    end

    // reset, directed table, random bursts, drain
    initial begin
        int          idx, sent, burst;
        logic [23:0] px;
        hsl_seen   = 0;
        mismatches = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, hand-typed results where known
        for (idx = 0; idx < NUM_CASES; idx++) begin
            px = {pixel_cases[idx].b, pixel_cases[idx].g, pixel_cases[idx].r};
            send_pixel(px, pixel_cases[idx].typed ? pixel_cases[idx].want : predict_hsl(px));
            if ($urandom_range(0, 2) == 0) idle_for($urandom_range(1, 4));
        end

        // random bursts with random gaps
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < NUM_RANDOM) begin
                if (sent == DRAIN_AT) begin
                    // pause until every pending item has come out
                    @(negedge i_clk);
                    i_s_tvalid <= 1'b0;
                    while (hsl_due.size() != 0) @(negedge i_clk);
                end
                px = rand_pixel();
                send_pixel(px, predict_hsl(px));
                sent++;
                burst--;
            end
            if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (hsl_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
